// ===== design/bdl_pkg.sv =====
// Shared types and constants for the bounded deque list block.
package bdl_pkg;

  localparam int CAP   = 32;
  localparam int KEY_W = 32;
  localparam int CNT_W = $clog2(CAP + 1);
  localparam int OUT_W = 32;

  localparam logic [2:0] CMD_INSERT    = 3'd0;
  localparam logic [2:0] CMD_DEL_KEY   = 3'd1;
  localparam logic [2:0] CMD_DEL_FIRST = 3'd2;
  localparam logic [2:0] CMD_DEL_LAST  = 3'd3;
  localparam logic [2:0] CMD_DUMP      = 3'd4;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NOTFOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY    = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_INS,
    OP_DEL_KEY,
    OP_DEL_FIRST,
    OP_DEL_LAST,
    OP_ROT
  } cell_op_t;

  typedef struct packed {
    cell_op_t           op;
    logic [KEY_W-1:0]   key;
  } chain_ctl_t;

  typedef struct packed {
    logic               empty;
    logic               full;
    logic               hit;
    logic [KEY_W-1:0]   front_key;
  } chain_sts_t;

endpackage

// ===== design/bounded_deque_list_with_key_delete.sv =====
// Bounded deque list: keeps up to 32 keys in front-to-back order in a row of
// cells, where cell zero always holds the front entry and the used cells form
// one unbroken run. Insert, delete by key, delete first and delete last each
// give one status beat; the whole row shifts or closes the gap at once, and
// delete by key removes the frontmost match found by a match chain that runs
// through every cell. A dump gives one beat per stored key: the row turns
// like a ring, cell zero feeding the output register with each beat, so after
// the last beat the list is back in its original order. An empty dump gives a
// single beat with status empty.
// While a dump is running no new command is taken. A new command enters only
// when the output register is empty or its beat is taken in that same cycle,
// so the single-beat commands run at one per cycle when the output is not
// stalled, and a stalled output holds the input off.
module bounded_deque_list_with_key_delete (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [2:0]          command,
  input  logic signed [31:0]  key_in,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [31:0]  key_out,
  output logic [1:0]          status,
  output logic                last_flag
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_DUMP = 1'b1;

  logic                          state;
  logic                          state_next;
  logic [bdl_pkg::CNT_W-1:0]     count;
  logic [bdl_pkg::CNT_W-1:0]     count_next;
  logic [bdl_pkg::CNT_W-1:0]     remaining;
  logic [bdl_pkg::CNT_W-1:0]     remaining_next;

  logic                          out_free;
  logic                          accept;
  logic                          load;
  logic [bdl_pkg::OUT_W-1:0]     key_out_next;
  logic [1:0]                    status_next;
  logic                          last_next;

  bdl_pkg::chain_ctl_t           ctl;
  bdl_pkg::chain_sts_t           sts;

  // The output register can take a beat when it is empty or being drained.
  assign out_free = !out_valid || !out_stall;
  assign in_stall = !((state == ST_IDLE) && out_free);
  assign accept   = in_valid && !in_stall;

  bdl_chain u_chain (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts)
  );

  always_comb begin
    state_next     = state;
    count_next     = count;
    remaining_next = remaining;
    load           = 1'b0;
    key_out_next   = '0;
    status_next    = bdl_pkg::ST_OK;
    last_next      = 1'b1;
    ctl.op         = bdl_pkg::OP_NOP;
    ctl.key        = bdl_pkg::KEY_W'($unsigned(key_in));

    if (accept) begin
      unique case (command)
        bdl_pkg::CMD_INSERT: begin
          load = 1'b1;
          if (sts.full) begin
            status_next = bdl_pkg::ST_FULL;
          end else begin
            ctl.op     = bdl_pkg::OP_INS;
            count_next = count + 1'b1;
          end
        end
        bdl_pkg::CMD_DEL_KEY: begin
          load = 1'b1;
          if (sts.empty) begin
            status_next = bdl_pkg::ST_EMPTY;
          end else if (sts.hit) begin
            ctl.op     = bdl_pkg::OP_DEL_KEY;
            count_next = count - 1'b1;
          end else begin
            status_next = bdl_pkg::ST_NOTFOUND;
          end
        end
        bdl_pkg::CMD_DEL_FIRST, bdl_pkg::CMD_DEL_LAST: begin
          load = 1'b1;
          if (sts.empty) begin
            status_next = bdl_pkg::ST_EMPTY;
          end else begin
            ctl.op     = (command == bdl_pkg::CMD_DEL_FIRST) ? bdl_pkg::OP_DEL_FIRST
                                                             : bdl_pkg::OP_DEL_LAST;
            count_next = count - 1'b1;
          end
        end
        bdl_pkg::CMD_DUMP: begin
          if (sts.empty) begin
            load        = 1'b1;
            status_next = bdl_pkg::ST_EMPTY;
          end else begin
            state_next     = ST_DUMP;
            remaining_next = count;
          end
        end
        default: begin
          // Unused command codes are taken and dropped without a result.
        end
      endcase
    end else if ((state == ST_DUMP) && out_free) begin
      // Emit the front key and turn the ring by one position.
      load           = 1'b1;
      key_out_next   = bdl_pkg::OUT_W'(sts.front_key);
      last_next      = (remaining == bdl_pkg::CNT_W'(1));
      ctl.op         = bdl_pkg::OP_ROT;
      remaining_next = remaining - 1'b1;
      if (remaining == bdl_pkg::CNT_W'(1)) begin
        state_next = ST_IDLE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      count     <= '0;
      remaining <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      remaining <= remaining_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      key_out   <= key_out_next;
      status    <= status_next;
      last_flag <= last_next;
    end
  end

  // The entry count agrees with the cell row about an empty list.
  a_count_empty: assert property (@(posedge clk) disable iff (rst)
    (count == '0) == sts.empty)
    else $error("entry count disagrees with empty cell row");

  // The entry count agrees with the cell row about a full list.
  a_count_full: assert property (@(posedge clk) disable iff (rst)
    (count == bdl_pkg::CNT_W'(bdl_pkg::CAP)) == sts.full)
    else $error("entry count disagrees with full cell row");

  // A running dump always has keys left to emit.
  a_dump_left: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |-> (remaining != '0))
    else $error("dump running with nothing left");

  // A dump leaves the entry count as it found it.
  a_dump_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DUMP) |=> (count == $past(count)))
    else $error("entry count changed during dump");

endmodule

// ===== design/bdl_cell.sv =====
// One list position: a key register and its valid bit.
module bdl_cell (
  input  logic                        clk,
  input  logic                        rst,
  input  bdl_pkg::chain_ctl_t         ctl,
  input  logic [bdl_pkg::KEY_W-1:0]   left_key,
  input  logic                        left_valid,
  input  logic [bdl_pkg::KEY_W-1:0]   right_key,
  input  logic                        right_valid,
  input  logic [bdl_pkg::KEY_W-1:0]   wrap_key,
  input  logic                        hit_in,
  output logic [bdl_pkg::KEY_W-1:0]   key,
  output logic                        valid,
  output logic                        hit_out
);

  logic [bdl_pkg::KEY_W-1:0] key_next;
  logic                      valid_next;

  // A hit at this cell or any cell in front of it makes this cell close the gap.
  assign hit_out = hit_in | (valid && (key == ctl.key));

  always_comb begin
    key_next   = key;
    valid_next = valid;
    unique case (ctl.op)
      bdl_pkg::OP_INS: begin
        key_next   = left_key;
        valid_next = left_valid;
      end
      bdl_pkg::OP_DEL_KEY: begin
        if (hit_out) begin
          key_next   = right_key;
          valid_next = right_valid;
        end
      end
      bdl_pkg::OP_DEL_FIRST: begin
        key_next   = right_key;
        valid_next = right_valid;
      end
      bdl_pkg::OP_DEL_LAST: begin
        if (valid && !right_valid) begin
          valid_next = 1'b0;
        end
      end
      bdl_pkg::OP_ROT: begin
        // The tail takes the front key so the ring is whole after a full turn.
        if (valid) begin
          key_next = right_valid ? right_key : wrap_key;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

  always_ff @(posedge clk) begin
    key <= key_next;
  end

endmodule

// ===== design/bdl_chain.sv =====
// Row of list cells with neighbor links, the match chain and list status.
module bdl_chain (
  input  logic                  clk,
  input  logic                  rst,
  input  bdl_pkg::chain_ctl_t   ctl,
  output bdl_pkg::chain_sts_t   sts
);

  logic [bdl_pkg::KEY_W-1:0] keys  [bdl_pkg::CAP];
  logic [bdl_pkg::CAP-1:0]   valids;
  logic [bdl_pkg::CAP:0]     hits;

  assign hits[0] = 1'b0;

  for (genvar i = 0; i < bdl_pkg::CAP; i++) begin : g_cell
    logic [bdl_pkg::KEY_W-1:0] lk;
    logic                      lv;
    logic [bdl_pkg::KEY_W-1:0] rk;
    logic                      rv;

    if (i == 0) begin : g_front
      assign lk = ctl.key;
      assign lv = 1'b1;
    end else begin : g_mid_l
      assign lk = keys[i-1];
      assign lv = valids[i-1];
    end

    if (i == bdl_pkg::CAP - 1) begin : g_back
      assign rk = '0;
      assign rv = 1'b0;
    end else begin : g_mid_r
      assign rk = keys[i+1];
      assign rv = valids[i+1];
    end

    bdl_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .left_key    (lk),
      .left_valid  (lv),
      .right_key   (rk),
      .right_valid (rv),
      .wrap_key    (keys[0]),
      .hit_in      (hits[i]),
      .key         (keys[i]),
      .valid       (valids[i]),
      .hit_out     (hits[i+1])
    );
  end

  assign sts.empty     = !valids[0];
  assign sts.full      = valids[bdl_pkg::CAP-1];
  assign sts.hit       = hits[bdl_pkg::CAP];
  assign sts.front_key = keys[0];

endmodule
